FILE: design/iad_pkg.sv
// Shared types and constants for the input activity detector.
`timescale 1ns / 1ps

package iad_pkg;

  localparam int TIME_BITS     = 48;
  localparam int POS_BITS      = 16;
  localparam int WHEEL_BITS    = 16;
  localparam int MS_BITS       = 20;
  localparam int SENS_BITS     = 16;
  localparam int MS_TO_US      = 1000;
  localparam int US_BITS       = MS_BITS + 10;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 20;
  localparam int MAG_BITS      = POS_BITS + 1;
  localparam int CMP_BITS      = (MAG_BITS > SENS_BITS) ? MAG_BITS : SENS_BITS;

  // Event codes on in_mode.
  typedef enum logic [2:0] {
    MODE_IDLE_CHECK = 3'd0,
    MODE_MOVE       = 3'd1,
    MODE_BUTTON     = 3'd2,
    MODE_KEY        = 3'd3,
    MODE_SUSPEND    = 3'd4,
    MODE_RESUME     = 3'd5,
    MODE_FORCE_IDLE = 3'd6
  } mode_t;

  // Encoded state as reported on out_detect_state.
  typedef enum logic [2:0] {
    MON_IDLE      = 3'd0,
    MON_NOISE     = 3'd1,
    MON_ACTIVE    = 3'd2,
    MON_SUSPENDED = 3'd3,
    MON_FORCED    = 3'd4
  } mon_state_t;

  // Internal one-hot state.
  typedef enum logic [4:0] {
    ST_IDLE      = 5'b00001,
    ST_NOISE     = 5'b00010,
    ST_ACTIVE    = 5'b00100,
    ST_SUSPENDED = 5'b01000,
    ST_FORCED    = 5'b10000
  } state_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_NOISE_GAP    = 2'd0,
    REG_ACTIVITY     = 2'd1,
    REG_IDLE_TIMEOUT = 2'd2,
    REG_SENSITIVITY  = 2'd3
  } reg_idx_t;

  function automatic mon_state_t encode_state(state_t st);
    mon_state_t code;
    code = MON_IDLE;
    unique case (st)
      ST_IDLE:      code = MON_IDLE;
      ST_NOISE:     code = MON_NOISE;
      ST_ACTIVE:    code = MON_ACTIVE;
      ST_SUSPENDED: code = MON_SUSPENDED;
      ST_FORCED:    code = MON_FORCED;
      default:      code = MON_IDLE;
    endcase
    return code;
  endfunction

  function automatic logic [US_BITS-1:0] ms_to_us(logic [MS_BITS-1:0] ms);
    return US_BITS'(ms) * US_BITS'(MS_TO_US);
  endfunction

endpackage

FILE: design/input_activity_detector.sv
// Input activity detector: classifies timestamped user-input events.
`timescale 1ns / 1ps

//  port group | direction | handshake            | contents
//  -----------+-----------+----------------------+------------------------------------------
//  in_*       | input     | in_valid / in_ready   | mode, now_us, pos_x, pos_y, wheel_step,
//             |           |                      | pressed
//  out_*      | output    | out_valid / out_ready | detect_state, active, action_seen
//  cfg_*      | input     | cfg_we (no wait)      | cfg_index selects register, cfg_wdata
//
//  One event per cycle sustained while out_ready stays high. Each event passes from
//  transfer in to result through the input register, then through the classify logic
//  into the result register. Event N+1 sees the state left by event N because the state
//  registers update at the same edge that loads the result register.
//  Reset (rst_n low, synchronous) empties both stages, restores the register
//  defaults and puts the detector into idle. A stalled result holds the result
//  register; the input register still takes one more event behind it.
//  Thresholds are scaled from ms to us in registers behind the configuration registers.

module input_activity_detector
  import iad_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  // event channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [2:0]                    in_mode,
  input  logic [TIME_BITS-1:0]          in_now_us,
  input  logic signed [POS_BITS-1:0]    in_pos_x,
  input  logic signed [POS_BITS-1:0]    in_pos_y,
  input  logic signed [WHEEL_BITS-1:0]  in_wheel_step,
  input  logic                          in_pressed,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    out_detect_state,
  output logic                          out_active,
  output logic                          out_action_seen,
  // configuration
  input  logic                          cfg_we,
  input  logic [CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [CFG_DATA_BITS-1:0]      cfg_wdata
);

  // Configuration registers (ms units) and their us-scaled copies.
  logic [MS_BITS-1:0]   noise_gap_ms_r;
  logic [MS_BITS-1:0]   activity_ms_r;
  logic [MS_BITS-1:0]   idle_ms_r;
  logic [SENS_BITS-1:0] sens_r;
  logic [US_BITS-1:0]   noise_gap_us_r;
  logic [US_BITS-1:0]   activity_us_r;
  logic [US_BITS-1:0]   idle_us_r;

  // Input register.
  logic                          s1_valid_r;
  logic [2:0]                    s1_mode_r;
  logic [TIME_BITS-1:0]          s1_now_r;
  logic [POS_BITS-1:0]           s1_pos_x_r;
  logic [POS_BITS-1:0]           s1_pos_y_r;
  logic [WHEEL_BITS-1:0]         s1_wheel_r;
  logic                          s1_pressed_r;

  // Detector state.
  state_t                state_r, state_nxt;
  logic [TIME_BITS-1:0]  first_us_r, first_us_nxt;
  logic [TIME_BITS-1:0]  last_us_r, last_us_nxt;
  logic [POS_BITS-1:0]   prev_x_r, prev_x_nxt;
  logic [POS_BITS-1:0]   prev_y_r, prev_y_nxt;
  logic                  held_r, held_nxt;

  // Result register.
  logic                  out_valid_r;
  mon_state_t            out_state_r;
  logic                  out_active_r;
  logic                  out_seen_r;

  logic                  advance;
  logic                  fire;
  logic                  in_xfer;
  logic                  seen;
  state_t                st_mid;
  logic [TIME_BITS-1:0]  el_last;
  logic [TIME_BITS-1:0]  el_first;
  logic [MAG_BITS-1:0]   dx, dy, dx_mag, dy_mag;
  logic                  moved;

  // ---------------------------------------------------------------------
  // Handshake: the result register frees up when empty or taken this cycle;
  // the input register drains into it whenever it frees up.
  // ---------------------------------------------------------------------
  assign advance  = !out_valid_r || out_ready;
  assign fire     = s1_valid_r && advance;
  assign in_ready = !s1_valid_r || advance;
  assign in_xfer  = in_valid && in_ready;

  // ---------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      noise_gap_ms_r <= MS_BITS'(9000);
      activity_ms_r  <= MS_BITS'(1000);
      idle_ms_r      <= MS_BITS'(5000);
      sens_r         <= SENS_BITS'(3);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NOISE_GAP:    noise_gap_ms_r <= cfg_wdata[MS_BITS-1:0];
        REG_ACTIVITY:     activity_ms_r  <= cfg_wdata[MS_BITS-1:0];
        REG_IDLE_TIMEOUT: idle_ms_r      <= cfg_wdata[MS_BITS-1:0];
        REG_SENSITIVITY:  sens_r         <= cfg_wdata[SENS_BITS-1:0];
        default:          ;
      endcase
    end
  end

  // Rescale every cycle; an event transferred right after a write reaches
  // the classify logic no earlier than the scaled values.
  always_ff @(posedge clk) begin
    noise_gap_us_r <= ms_to_us(noise_gap_ms_r);
    activity_us_r  <= ms_to_us(activity_ms_r);
    idle_us_r      <= ms_to_us(idle_ms_r);
  end

  // ---------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_mode_r    <= in_mode;
      s1_now_r     <= in_now_us;
      s1_pos_x_r   <= in_pos_x;
      s1_pos_y_r   <= in_pos_y;
      s1_wheel_r   <= in_wheel_step;
      s1_pressed_r <= in_pressed;
    end
  end

  // ---------------------------------------------------------------------
  // Classify logic
  // ---------------------------------------------------------------------
  // Time differences wrap modulo 2^TIME_BITS.
  assign el_last  = s1_now_r - last_us_r;
  assign el_first = s1_now_r - first_us_r;

  // Pointer step magnitudes, one bit wider than a position.
  assign dx     = {s1_pos_x_r[POS_BITS-1], s1_pos_x_r} - {prev_x_r[POS_BITS-1], prev_x_r};
  assign dy     = {s1_pos_y_r[POS_BITS-1], s1_pos_y_r} - {prev_y_r[POS_BITS-1], prev_y_r};
  assign dx_mag = dx[MAG_BITS-1] ? (~dx + MAG_BITS'(1)) : dx;
  assign dy_mag = dy[MAG_BITS-1] ? (~dy + MAG_BITS'(1)) : dy;
  assign moved  = (CMP_BITS'(dx_mag) >= CMP_BITS'(sens_r)) ||
                  (CMP_BITS'(dy_mag) >= CMP_BITS'(sens_r)) ||
                  (s1_wheel_r != '0) || held_r;

  always_comb begin
    st_mid       = state_r;
    seen         = 1'b0;
    prev_x_nxt   = prev_x_r;
    prev_y_nxt   = prev_y_r;
    held_nxt     = held_r;
    last_us_nxt  = last_us_r;
    first_us_nxt = first_us_r;

    // Event-specific effects.
    unique case (s1_mode_r)
      MODE_IDLE_CHECK: begin
        if (state_r == ST_ACTIVE && el_last > TIME_BITS'(idle_us_r)) begin
          st_mid = ST_IDLE;
        end
      end
      MODE_MOVE: begin
        prev_x_nxt = s1_pos_x_r;
        prev_y_nxt = s1_pos_y_r;
        seen       = moved;
      end
      MODE_BUTTON: begin
        held_nxt = s1_pressed_r;
        seen     = s1_pressed_r;
      end
      MODE_KEY: begin
        seen = 1'b1;
      end
      MODE_SUSPEND: begin
        st_mid = ST_SUSPENDED;
      end
      MODE_RESUME: begin
        st_mid = ST_IDLE;
      end
      MODE_FORCE_IDLE: begin
        // Ignored while suspended.
        if (state_r != ST_SUSPENDED) begin
          st_mid      = ST_FORCED;
          last_us_nxt = '0;
        end
      end
      default: ;
    endcase

    state_nxt = st_mid;

    // Counted activity advances the idle/noise/active progression.
    if (seen) begin
      unique case (st_mid) inside
        ST_IDLE, ST_FORCED: begin
          first_us_nxt = s1_now_r;
          state_nxt    = (activity_us_r == '0) ? ST_ACTIVE : ST_NOISE;
        end
        ST_NOISE: begin
          if (el_last > TIME_BITS'(noise_gap_us_r)) begin
            // Quiet gap too long: restart the window.
            first_us_nxt = s1_now_r;
          end else if (el_first >= TIME_BITS'(activity_us_r)) begin
            state_nxt = ST_ACTIVE;
          end
        end
        default: ;
      endcase
      last_us_nxt = s1_now_r;
    end
  end

  // ---------------------------------------------------------------------
  // State registers: advance together with the result register.
  // A configuration write drops the state to idle.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      first_us_r <= '0;
      last_us_r  <= '0;
      prev_x_r   <= '0;
      prev_y_r   <= '0;
      held_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        state_r <= ST_IDLE;
      end else if (fire) begin
        state_r <= state_nxt;
      end
      if (fire) begin
        first_us_r <= first_us_nxt;
        last_us_r  <= last_us_nxt;
        prev_x_r   <= prev_x_nxt;
        prev_y_r   <= prev_y_nxt;
        held_r     <= held_nxt;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_state_r  <= encode_state(state_nxt);
      out_active_r <= (state_nxt == ST_ACTIVE);
      out_seen_r   <= seen;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_detect_state  = out_state_r;
  assign out_active        = out_active_r;
  assign out_action_seen   = out_seen_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("event input stalled while result register is empty");

  a_active_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_active == (out_detect_state == MON_ACTIVE)))
    else $error("active flag disagrees with detect_state");

  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> (state_r == ST_IDLE))
    else $error("configuration write did not return state to idle");

  a_suspend: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && s1_mode_r == MODE_SUSPEND && !cfg_we) |=> (state_r == ST_SUSPENDED))
    else $error("suspend event did not suspend");

endmodule

FILE: tb/iad_activity_checker.sv
// Checker for the input activity detector: predicts each result and compares it.
`timescale 1ns / 1ps

module iad_activity_checker
  import iad_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [2:0]                    in_mode,
  input  logic [TIME_BITS-1:0]          in_now_us,
  input  logic signed [POS_BITS-1:0]    in_pos_x,
  input  logic signed [POS_BITS-1:0]    in_pos_y,
  input  logic signed [WHEEL_BITS-1:0]  in_wheel_step,
  input  logic                          in_pressed,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [2:0]                    out_detect_state,
  input  logic                          out_active,
  input  logic                          out_action_seen,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [CFG_DATA_BITS-1:0]      cfg_wdata,
  output int                            mismatches,
  output int                            pending
);

  typedef struct packed {
    logic [2:0] state;
    logic       active;
    logic       seen;
  } activity_result_t;

  // Thresholds as last written.
  logic [MS_BITS-1:0]         gap_ms;
  logic [MS_BITS-1:0]         span_ms;
  logic [MS_BITS-1:0]         idle_ms;
  logic [SENS_BITS-1:0]       sens;

  // Predicted detector state.
  mon_state_t                 mon;
  logic [TIME_BITS-1:0]       first_us;
  logic [TIME_BITS-1:0]       last_us;
  logic signed [POS_BITS-1:0] last_x;
  logic signed [POS_BITS-1:0] last_y;
  logic                       held;

  activity_result_t           expected_results[$];

  function automatic longint unsigned to_us(logic [MS_BITS-1:0] ms);
    return longint'(ms) * MS_TO_US;
  endfunction

  // Time difference, wrapped at the timestamp width.
  function automatic logic [TIME_BITS-1:0] since(logic [TIME_BITS-1:0] now,
                                                 logic [TIME_BITS-1:0] then);
    return now - then;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic register_activity(logic [TIME_BITS-1:0] now);
    if (mon == MON_IDLE || mon == MON_FORCED) begin
      first_us = now;
      mon = (span_ms == '0) ? MON_ACTIVE : MON_NOISE;
    end else if (mon == MON_NOISE) begin
      if (since(now, last_us) > to_us(gap_ms)) begin
        first_us = now;
      end else if (since(now, first_us) >= to_us(span_ms)) begin
        mon = MON_ACTIVE;
      end
    end
    last_us = now;
  endtask

  task automatic classify_event(input logic [2:0] mode,
                                input logic [TIME_BITS-1:0] now,
                                input logic signed [POS_BITS-1:0] x,
                                input logic signed [POS_BITS-1:0] y,
                                input logic signed [WHEEL_BITS-1:0] wheel,
                                input logic pressed,
                                output activity_result_t r);
    logic seen;
    int   dx;
    int   dy;
    seen = 1'b0;
    case (mode)
      MODE_IDLE_CHECK: begin
        if (mon == MON_ACTIVE && since(now, last_us) > to_us(idle_ms)) mon = MON_IDLE;
      end
      MODE_MOVE: begin
        dx = int'(x) - int'(last_x);
        dy = int'(y) - int'(last_y);
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        last_x = x;
        last_y = y;
        if (dx >= int'(sens) || dy >= int'(sens) || wheel != '0 || held) seen = 1'b1;
      end
      MODE_BUTTON: begin
        held = pressed;
        seen = pressed;
      end
      MODE_KEY:     seen = 1'b1;
      MODE_SUSPEND: mon = MON_SUSPENDED;
      MODE_RESUME:  mon = MON_IDLE;
      MODE_FORCE_IDLE: begin
        if (mon != MON_SUSPENDED) begin
          mon = MON_FORCED;
          last_us = '0;
        end
      end
      default: ;
    endcase
    if (seen) register_activity(now);
    r.state  = mon;
    r.active = (mon == MON_ACTIVE);
    r.seen   = seen;
  endtask

  always @(posedge clk) begin : watch
    activity_result_t want;
    activity_result_t got;
    if (!rst_n) begin
      gap_ms     = 20'd9000;
      span_ms    = 20'd1000;
      idle_ms    = 20'd5000;
      sens       = 16'd3;
      mon        = MON_IDLE;
      first_us   = '0;
      last_us    = '0;
      last_x     = '0;
      last_y     = '0;
      held       = 1'b0;
      mismatches = 0;
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_NOISE_GAP:    gap_ms  = cfg_wdata;
          REG_ACTIVITY:     span_ms = cfg_wdata;
          REG_IDLE_TIMEOUT: idle_ms = cfg_wdata;
          REG_SENSITIVITY:  sens    = cfg_wdata[SENS_BITS-1:0];
          default: ;
        endcase
        mon = MON_IDLE;
      end
      if (in_valid && in_ready) begin
        classify_event(in_mode, in_now_us, in_pos_x, in_pos_y, in_wheel_step,
                       in_pressed, want);
        expected_results.push_back(want);
      end
      if (out_valid && out_ready) begin
        got = '{out_detect_state, out_active, out_action_seen};
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing expected", int'(got), -1);
        end else begin
          want = expected_results.pop_front();
          if (got.state !== want.state)
            report_mismatch("detect_state", int'(got.state), int'(want.state));
          if (got.active !== want.active)
            report_mismatch("active", int'(got.active), int'(want.active));
          if (got.seen !== want.seen)
            report_mismatch("action_seen", int'(got.seen), int'(want.seen));
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

FILE: tb/testbench.sv
// Top-level bench for the input activity detector: stimulus, idling and verdict.
`timescale 1ns / 1ps

module testbench
  import iad_pkg::*;
();

  // Mode code with no event behind it; the detector must leave everything alone.
  localparam logic [2:0] MODE_UNUSED = 3'd7;

  logic                         clk           = 1'b0;
  logic                         rst_n         = 1'b0;
  logic                         in_valid      = 1'b0;
  logic                         in_ready;
  logic [2:0]                   in_mode       = MODE_IDLE_CHECK;
  logic [TIME_BITS-1:0]         in_now_us     = '0;
  logic signed [POS_BITS-1:0]   in_pos_x      = '0;
  logic signed [POS_BITS-1:0]   in_pos_y      = '0;
  logic signed [WHEEL_BITS-1:0] in_wheel_step = '0;
  logic                         in_pressed    = 1'b0;
  logic                         out_valid;
  logic                         out_ready     = 1'b0;
  logic [2:0]                   out_detect_state;
  logic                         out_active;
  logic                         out_action_seen;
  logic                         cfg_we        = 1'b0;
  logic [CFG_IDX_BITS-1:0]      cfg_index     = REG_NOISE_GAP;
  logic [CFG_DATA_BITS-1:0]     cfg_wdata     = '0;

  int mismatches;
  int pending;

  // Idling odds, in percent, for the current phase.
  int send_idle_pct = 0;
  int stall_pct     = 0;

  // Thresholds as last written; the time steps aim at their edges.
  logic [MS_BITS-1:0]           cur_gap_ms  = 20'd9000;
  logic [MS_BITS-1:0]           cur_span_ms = 20'd1000;
  logic [MS_BITS-1:0]           cur_idle_ms = 20'd5000;
  logic [SENS_BITS-1:0]         cur_sens    = 16'd3;

  // Event timeline and the pointer position the detector last saw.
  logic [TIME_BITS-1:0]         now_us = '0;
  logic signed [POS_BITS-1:0]   ptr_x  = '0;
  logic signed [POS_BITS-1:0]   ptr_y  = '0;

  input_activity_detector dut (.*);

  iad_activity_checker chk (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receiver: stall at random with the phase's odds.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Hand one event to the detector and hold it until the transfer.
  // Valid drops only when a gap is taken, so back-to-back events keep it high.
  task automatic send_event(logic [2:0] mode, logic [TIME_BITS-1:0] t,
                            logic signed [POS_BITS-1:0] x, logic signed [POS_BITS-1:0] y,
                            logic signed [WHEEL_BITS-1:0] w, logic p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_mode       <= mode;
    in_now_us     <= t;
    in_pos_x      <= x;
    in_pos_y      <= y;
    in_wheel_step <= w;
    in_pressed    <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stop sending, wait for every expected result, then let the pipe settle.
  task automatic drain_results(int settle);
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0 && waited < 4000) begin
      @(posedge clk);
      waited++;
    end
    repeat (settle) @(posedge clk);
  endtask

  // Write all four thresholds while the detector is idle.
  // The sensitivity write carries junk in the bits above the register.
  task automatic write_settings(logic [MS_BITS-1:0] gap, logic [MS_BITS-1:0] span,
                                logic [MS_BITS-1:0] idle, logic [SENS_BITS-1:0] s);
    logic [CFG_DATA_BITS-1:0] vals [4];
    reg_idx_t                 r;
    drain_results(4);
    vals[REG_NOISE_GAP]    = gap;
    vals[REG_ACTIVITY]     = span;
    vals[REG_IDLE_TIMEOUT] = idle;
    vals[REG_SENSITIVITY]  = {4'($urandom), s};
    r = REG_NOISE_GAP;
    repeat (4) begin
      cfg_we    <= 1'b1;
      cfg_index <= r;
      cfg_wdata <= vals[r];
      @(posedge clk);
      r = r.next();
    end
    cfg_we <= 1'b0;
    // let the ms-to-us scaling settle before the next event
    repeat (3) @(posedge clk);
    cur_gap_ms  = gap;
    cur_span_ms = span;
    cur_idle_ms = idle;
    cur_sens    = s;
  endtask

  // New pointer coordinate: full random, a small wiggle, or a step within one of the sensitivity.
  function automatic logic signed [POS_BITS-1:0] pick_coord(logic signed [POS_BITS-1:0] prev);
    case ($urandom_range(3))
      0: return POS_BITS'($urandom);
      1: return prev + POS_BITS'($urandom_range(8)) - POS_BITS'(4);
      default: begin
        if ($urandom_range(1) != 0)
          return prev + cur_sens + POS_BITS'($urandom_range(2)) - POS_BITS'(1);
        return prev - cur_sens + POS_BITS'($urandom_range(2)) - POS_BITS'(1);
      end
    endcase
  endfunction

  // One random event. Time steps cluster on the threshold edges so that the
  // noise window, the restart and the idle fall-back all get hit exactly.
  task automatic send_random_event();
    logic [2:0]                   mode;
    logic signed [POS_BITS-1:0]   x;
    logic signed [POS_BITS-1:0]   y;
    logic signed [WHEEL_BITS-1:0] w;
    int                           pick;
    pick = $urandom_range(99);
    if (pick < 22)      mode = MODE_KEY;
    else if (pick < 52) mode = MODE_MOVE;
    else if (pick < 66) mode = MODE_BUTTON;
    else if (pick < 84) mode = MODE_IDLE_CHECK;
    else if (pick < 88) mode = MODE_SUSPEND;
    else if (pick < 92) mode = MODE_RESUME;
    else if (pick < 96) mode = MODE_FORCE_IDLE;
    else                mode = MODE_UNUSED;

    pick = $urandom_range(99);
    if (pick < 30)
      now_us = now_us + TIME_BITS'($urandom_range(2000));
    else if (pick < 50)
      now_us = now_us + TIME_BITS'(cur_span_ms) * TIME_BITS'(MS_TO_US)
               + TIME_BITS'($urandom_range(2)) - TIME_BITS'(1);
    else if (pick < 68)
      now_us = now_us + TIME_BITS'(cur_gap_ms) * TIME_BITS'(MS_TO_US)
               + TIME_BITS'($urandom_range(2)) - TIME_BITS'(1);
    else if (pick < 86)
      now_us = now_us + TIME_BITS'(cur_idle_ms) * TIME_BITS'(MS_TO_US)
               + TIME_BITS'($urandom_range(2)) - TIME_BITS'(1);
    else if (pick < 97)
      now_us = now_us + TIME_BITS'($urandom);
    else
      now_us = TIME_BITS'({$urandom, $urandom});   // jump anywhere, wrap included

    x = ptr_x;
    y = ptr_y;
    if (mode == MODE_MOVE) begin
      x = pick_coord(ptr_x);
      y = pick_coord(ptr_y);
      ptr_x = x;
      ptr_y = y;
    end
    w = ($urandom_range(3) == 0) ? WHEEL_BITS'($urandom) : '0;
    send_event(mode, now_us, x, y, w, 1'($urandom_range(1)));
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed pass on the reset thresholds: 9 s gap, 1 s span, 5 s idle, step 3.
    send_event(MODE_IDLE_CHECK, 48'd100, 0, 0, 0, 1'b0);
    send_event(MODE_UNUSED, 48'd200, 5, 5, 7, 1'b1);              // unused mode
    send_event(MODE_MOVE, 48'd1000, 3, 0, 0, 1'b0);               // step equals sensitivity
    send_event(MODE_MOVE, 48'd2000, 5, -2, 0, 1'b0);              // step just below it
    send_event(MODE_KEY, 48'd501000, 0, 0, 0, 1'b0);              // window still short
    send_event(MODE_KEY, 48'd1001000, 0, 0, 0, 1'b0);             // window reaches span
    send_event(MODE_KEY, 48'd2001000, 0, 0, 0, 1'b0);             // activity while active
    send_event(MODE_IDLE_CHECK, 48'd7001000, 0, 0, 0, 1'b0);      // exactly at timeout
    send_event(MODE_IDLE_CHECK, 48'd7001001, 0, 0, 0, 1'b0);      // one past timeout
    send_event(MODE_BUTTON, 48'd7002000, 0, 0, 0, 1'b1);          // press
    send_event(MODE_MOVE, 48'd7003000, 5, -2, 0, 1'b0);           // no step, button held
    send_event(MODE_BUTTON, 48'd7004000, 0, 0, 0, 1'b0);          // release
    send_event(MODE_MOVE, 48'd7005000, 6, -2, -32768, 1'b0);      // wheel only
    send_event(MODE_MOVE, 48'd7005000, 6, -2, 0, 1'b0);           // nothing moved
    send_event(MODE_KEY, 48'd16005001, 0, 0, 0, 1'b0);            // quiet gap restarts window
    send_event(MODE_SUSPEND, 48'd16006000, 0, 0, 0, 1'b0);
    send_event(MODE_KEY, 48'd16007000, 0, 0, 0, 1'b0);            // activity while suspended
    send_event(MODE_FORCE_IDLE, 48'd16008000, 0, 0, 0, 1'b0);     // ignored while suspended
    send_event(MODE_RESUME, 48'd16009000, 0, 0, 0, 1'b0);
    send_event(MODE_FORCE_IDLE, 48'd16010000, 0, 0, 0, 1'b0);
    send_event(MODE_KEY, 48'd16011000, 0, 0, 0, 1'b0);            // forced idle to noise
    send_event(MODE_MOVE, 48'd16012000, -32768, 32767, 32767, 1'b0);
    send_event(MODE_MOVE, 48'd16013000, 32767, -32768, 0, 1'b1);  // largest steps
    send_event(MODE_KEY, 48'hFFFF_FFFF_FFFF, 0, 0, 0, 1'b0);      // top of the time range
    send_event(MODE_KEY, 48'd999999, 0, 0, 0, 1'b0);              // difference wraps
    ptr_x  = 32767;
    ptr_y  = -32768;
    now_us = 48'd999999;

    // Random phases: each one rewrites every threshold, then cycles the idling:
    // none, sender only, receiver only, both.
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: write_settings(20'd5, 20'd2, 20'd3, 16'd3);
        1: write_settings('0, '0, '0, '0);
        2: write_settings('1, '1, '1, '1);
        3: write_settings(20'd9000, 20'd1000, 20'd5000, 16'd3);
        4: write_settings(MS_BITS'($urandom_range(20)), MS_BITS'($urandom_range(20)),
                          MS_BITS'($urandom_range(20)), SENS_BITS'($urandom_range(8)));
        5: write_settings(20'd1, '0, 20'd1, 16'd1);
        6: write_settings(MS_BITS'($urandom), MS_BITS'($urandom),
                          MS_BITS'($urandom), SENS_BITS'($urandom));
        default: write_settings(20'd2, 20'd1, 20'd2, 16'd2);
      endcase
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 58; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 58; end
        default: begin send_idle_pct = 38; stall_pct = 38; end
      endcase
      repeat (94) send_random_event();
    end

    drain_results(8);
    if (mismatches == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
